// ----- rtl/max_heap_priority_queue_core_assert.svh -----
// assertion macros for the heap queue rtl, used by the datapath
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mhpq_pkg.sv -----
// shared constants, codes and controller/datapath types for the heap queue
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = CNT_W + 1;
    localparam int ENTRY_W  = 11;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_LAST  = 4'd2;
    localparam logic [OP_W-1:0] OP_UP    = 4'd3;
    localparam logic [OP_W-1:0] OP_UPCMP = 4'd4;
    localparam logic [OP_W-1:0] OP_DN    = 4'd5;
    localparam logic [OP_W-1:0] OP_DNL   = 4'd6;
    localparam logic [OP_W-1:0] OP_DNR   = 4'd7;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic pos_root;
        logic l_out;
        logic r_out;
        logic up_move;
        logic dn_move_l;
        logic dn_move_r;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/mhpq_ram.sv -----
// generic single write port, single read port ram with registered read
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mhpq_datapath.sv -----
// heap datapath: entry count, sift position and value, heap ram, result register
`include "max_heap_priority_queue_core_assert.svh"

module mhpq_datapath import mhpq_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_command,
    input  logic signed [DATA_W-1:0]   i_value,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic signed [DATA_W-1:0]   o_removed_value,
    output logic signed [DATA_W-1:0]   o_top_value,
    output logic [ENTRY_W-1:0]         o_entry_count,
    output logic [STATUS_W-1:0]        o_status
);

    function automatic logic [ADDR_W-1:0] pos_addr(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] d;
        d = p - 1'b1;
        return d[ADDR_W-1:0];
    endfunction

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_bpos;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_big;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] r_removed;
    logic [STATUS_W-1:0]      r_status;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_o_removed;
    logic signed [DATA_W-1:0] r_o_top;
    logic [ENTRY_W-1:0]       r_o_count;
    logic [STATUS_W-1:0]      r_o_status;

    logic [POS_W-1:0]         w_left;
    logic [POS_W-1:0]         w_right;
    logic [POS_W-1:0]         w_count_ext;
    logic [CNT_W-1:0]         w_parent;
    logic [DATA_W-1:0]        w_rd_data;
    logic signed [DATA_W-1:0] w_rd_val;
    logic                     w_r_wins;
    logic signed [DATA_W-1:0] w_cand;
    logic [CNT_W-1:0]         w_cand_pos;

    logic                     w_wr_en;
    logic signed [DATA_W-1:0] w_wr_data;
    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr;

    assign w_left      = {r_pos, 1'b0};
    assign w_right     = {r_pos, 1'b1};
    assign w_count_ext = {1'b0, r_count};
    assign w_parent    = r_pos >> 1;
    assign w_rd_val    = $signed(w_rd_data);
    assign w_r_wins    = w_rd_val > r_big;
    assign w_cand      = w_r_wins ? w_rd_val : r_big;
    assign w_cand_pos  = w_r_wins ? w_right[CNT_W-1:0] : r_bpos;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CNT_W'(CAPACITY));
    assign o_stat.pos_root   = (r_pos == CNT_W'(1));
    assign o_stat.l_out      = (w_left > w_count_ext);
    assign o_stat.r_out      = (w_right > w_count_ext);
    assign o_stat.up_move    = (r_val > w_rd_val);
    assign o_stat.dn_move_l  = (w_rd_val > r_val);
    assign o_stat.dn_move_r  = (w_cand > r_val);
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_data = r_val;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (i_command == CMD_REMOVE && !o_stat.count_zero) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = pos_addr(w_count_ext);
                end
            end
            OP_UP: begin
                if (o_stat.pos_root) begin
                    w_wr_en = 1'b1;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = pos_addr({1'b0, w_parent});
                end
            end
            OP_UPCMP: begin
                w_wr_en   = 1'b1;
                w_wr_data = o_stat.up_move ? w_rd_val : r_val;
            end
            OP_DN: begin
                if (o_stat.l_out) begin
                    w_wr_en = 1'b1;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = pos_addr(w_left);
                end
            end
            OP_DNL: begin
                if (!o_stat.r_out) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = pos_addr(w_right);
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_data = o_stat.dn_move_l ? w_rd_val : r_val;
                end
            end
            OP_DNR: begin
                w_wr_en   = 1'b1;
                w_wr_data = o_stat.dn_move_r ? w_cand : r_val;
            end
            default: begin
            end
        endcase
    end

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (pos_addr({1'b0, r_pos})),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_LOAD) begin
                if (i_command == CMD_INSERT && !o_stat.count_full) begin
                    r_count <= r_count + 1'b1;
                end else if (i_command == CMD_REMOVE && !o_stat.count_zero) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && o_stat.pos_root) begin
            r_top <= w_wr_data;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_val     <= i_value;
                r_removed <= '0;
                r_status  <= ST_OK;
                if (i_command == CMD_INSERT) begin
                    if (o_stat.count_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_pos <= r_count + 1'b1;
                    end
                end else begin
                    if (o_stat.count_zero) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_removed <= r_top;
                    end
                end
            end
            OP_LAST: begin
                r_val <= w_rd_val;
                r_pos <= CNT_W'(1);
            end
            OP_UPCMP: begin
                if (o_stat.up_move) begin
                    r_pos <= w_parent;
                end
            end
            OP_DNL: begin
                if (!o_stat.r_out) begin
                    r_big  <= w_rd_val;
                    r_bpos <= w_left[CNT_W-1:0];
                end else if (o_stat.dn_move_l) begin
                    r_pos <= w_left[CNT_W-1:0];
                end
            end
            OP_DNR: begin
                if (o_stat.dn_move_r) begin
                    r_pos <= w_cand_pos;
                end
            end
            OP_OUT: begin
                r_o_removed <= r_removed;
                r_o_top     <= o_stat.count_zero ? '0 : r_top;
                r_o_count   <= ENTRY_W'(r_count);
                r_o_status  <= r_status;
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_o_removed;
    assign o_top_value     = r_o_top;
    assign o_entry_count   = r_o_count;
    assign o_status        = r_o_status;

    `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `MHPQ_ASSERT_NOW(a_wr_in_heap, w_wr_en, (r_pos != '0) && ((r_pos <= r_count) || (r_count == '0)), "heap write outside entries")
    `MHPQ_ASSERT_NEXT(a_fail_keeps_count, (i_cmd.op == OP_LOAD) && ((i_command == CMD_INSERT && o_stat.count_full) || (i_command == CMD_REMOVE && o_stat.count_zero)), r_count == $past(r_count), "rejected beat changed count")
    `MHPQ_ASSERT_NOW(a_out_slot_free, i_cmd.op == OP_OUT, o_stat.out_free, "result overwrites pending beat")

endmodule

// ----- rtl/mhpq_ctrl.sv -----
// heap controller: sequences insert sift-up and remove sift-down over the datapath
module mhpq_ctrl import mhpq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output logic     o_stall,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_UPCMP = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_DN    = 3'd4;
    localparam logic [2:0] S_DNL   = 3'd5;
    localparam logic [2:0] S_DNR   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_command == CMD_INSERT) begin
                        n_state = i_stat.count_full ? S_DONE : S_UP;
                    end else begin
                        n_state = i_stat.count_zero ? S_DONE : S_LAST;
                    end
                end
            end
            S_UP: begin
                o_cmd.op = OP_UP;
                n_state  = i_stat.pos_root ? S_DONE : S_UPCMP;
            end
            S_UPCMP: begin
                o_cmd.op = OP_UPCMP;
                n_state  = i_stat.up_move ? S_UP : S_DONE;
            end
            S_LAST: begin
                o_cmd.op = OP_LAST;
                n_state  = S_DN;
            end
            S_DN: begin
                o_cmd.op = OP_DN;
                n_state  = i_stat.l_out ? S_DONE : S_DNL;
            end
            S_DNL: begin
                o_cmd.op = OP_DNL;
                if (!i_stat.r_out) begin
                    n_state = S_DNR;
                end else begin
                    n_state = i_stat.dn_move_l ? S_DN : S_DONE;
                end
            end
            S_DNR: begin
                o_cmd.op = OP_DNR;
                n_state  = i_stat.dn_move_r ? S_DN : S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/max_heap_priority_queue_core.sv -----
// insert: load, then per level a parent read (up) and compare-write (upcmp), then out
// remove: load, last, then per level dn, dnl and (with a right child) dnr, then out
// a full insert or empty remove skips to out; one beat in flight at a time
// a result still held by the receiver delays the next result until it is taken
// the level loop is set by the single read port of the heap ram, registered read
// synchronous active-low reset empties the heap and drops any pending result
module max_heap_priority_queue_core import mhpq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic [ENTRY_W-1:0]       o_entry_count,
    output logic [STATUS_W-1:0]      o_status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mhpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    mhpq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

endmodule

// ----- verif/max_heap_priority_queue_core_tb.sv -----
// self-checking testbench for the heap queue core: shadow heap, bursty sender, stalling receiver
module max_heap_priority_queue_core_tb;
    import mhpq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] top;
        logic [ENTRY_W-1:0]       entries;
        logic [STATUS_W-1:0]      status;
    } t_heap_outcome;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_CLOGGED} t_rx_mode;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    class heap_tracker;
        logic signed [DATA_W-1:0] slots [1:CAPACITY];
        int fill = 0;
        int mismatches = 0;
        t_heap_outcome awaited_results [$];

        function int held();
            return fill;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void swap_slots(int a, int b);
            logic signed [DATA_W-1:0] t;
            t = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        // shadow the heap and queue what the core must report for this beat
        function void note_command(logic cmd, logic signed [DATA_W-1:0] val);
            t_heap_outcome o;
            int pos;
            int big;
            bit settled;
            o.removed = '0;
            o.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                if (fill >= CAPACITY) begin
                    o.status = ST_FULL;
                end else begin
                    fill++;
                    slots[fill] = val;
                    pos = fill;
                    while (pos > 1 && slots[pos] > slots[pos / 2]) begin
                        swap_slots(pos, pos / 2);
                        pos = pos / 2;
                    end
                end
            end else if (fill == 0) begin
                o.status = ST_EMPTY;
            end else begin
                o.removed = slots[1];
                slots[1] = slots[fill];
                fill--;
                pos = 1;
                settled = 1'b0;
                while (!settled && 2 * pos <= fill) begin
                    big = 2 * pos;
                    if (big + 1 <= fill && slots[big + 1] > slots[big])
                        big = big + 1;
                    if (slots[big] > slots[pos]) begin
                        swap_slots(pos, big);
                        pos = big;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
            o.top = (fill > 0) ? slots[1] : '0;
            o.entries = ENTRY_W'(fill);
            awaited_results.insert(awaited_results.size(), o);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] removed,
                                   logic signed [DATA_W-1:0] top,
                                   logic [ENTRY_W-1:0] entries,
                                   logic [STATUS_W-1:0] status);
            t_heap_outcome e;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: removed %0d top %0d count %0d status %0d",
                             removed, top, entries, status);
                return;
            end
            e = awaited_results.pop_front();
            if (e.removed !== removed || e.top !== top || e.entries !== entries ||
                e.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "mismatch exp/act: removed %0d/%0d top %0d/%0d count %0d/%0d %s",
                        e.removed, removed, e.top, top, e.entries, entries,
                        $sformatf("status %0d/%0d", e.status, status));
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_command = CMD_INSERT;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_removed_value;
    logic signed [DATA_W-1:0] o_top_value;
    logic [ENTRY_W-1:0]       o_entry_count;
    logic [STATUS_W-1:0]      o_status;

    heap_tracker book = new();
    int burst_left = 0;
    int rx_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    max_heap_priority_queue_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_removed_value(o_removed_value),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    i_stall = 1'b0;
                RX_CHOPPY:  i_stall = 1'($urandom_range(0, 1));
                default:    i_stall = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            book.check_result(o_removed_value, o_top_value, o_entry_count, o_status);
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at a falling edge after the beat is taken, idling between bursts
    task automatic send_item(input logic cmd, input logic signed [DATA_W-1:0] val);
        i_valid = 1'b1;
        i_command = cmd;
        i_value = val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_command(cmd, val);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            i_command = 1'($urandom_range(0, 1));
            i_value = $urandom;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty removes, extremes, equal values, drain past empty
        send_item(CMD_REMOVE, VAL_MAX);
        send_item(CMD_REMOVE, $urandom);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 1);
        send_item(CMD_INSERT, 5);
        send_item(CMD_INSERT, 5);
        send_item(CMD_INSERT, 5);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        repeat (11) send_item(CMD_REMOVE, $urandom);

        repeat (150) send_item(1'($urandom_range(0, 1)), pick_value());

        // grow to capacity, then hammer the full heap
        while (book.held() < CAPACITY)
            send_item(($urandom_range(0, 9) == 0) ? CMD_REMOVE : CMD_INSERT, pick_value());
        repeat (6) send_item(CMD_INSERT, pick_value());

        repeat (250) send_item(($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_REMOVE,
                               pick_value());

        i_valid = 1'b0;
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("PASS max_heap_priority_queue_core");
        else
            $display("FAIL max_heap_priority_queue_core");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL max_heap_priority_queue_core");
        $finish;
    end

endmodule
